FILE: src/button_gesture_classifier_top_assert.svh
// Assertion macros for the button gesture classifier.
// Used by button_gesture_classifier_top; no other dependencies.
// The macros expand to nothing when SYNTHESIS is defined.
`ifndef BUTTON_GESTURE_CLASSIFIER_TOP_ASSERT_SVH
`define BUTTON_GESTURE_CLASSIFIER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Checks that a condition holds at every rising edge outside reset.
`define BGC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define BGC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define BGC_ASSERT(lbl, clk, rst, prop, msg)
`define BGC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

FILE: src/bgc_pkg.sv
// Shared types and constants for the button gesture classifier.
// No dependencies; imported by every module of the block.
`default_nettype none

package bgc_pkg;

   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 8;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   // Debounce interval in milliseconds.
   localparam logic [31:0] DEBOUNCE_MS = 32'd50;

   localparam logic [15:0] CLICK_MIN_RESET     = 16'd100;
   localparam logic [15:0] LONG_PRESS_RESET    = 16'd1000;
   localparam logic [15:0] DOUBLE_WINDOW_RESET = 16'd300;

   typedef enum logic [2:0] {
      G_RELEASE       = 3'd0,
      G_PRESS         = 3'd1,
      G_PRESSED       = 3'd2,
      G_LONG_PRESSED  = 3'd3,
      G_LONG_PRESSING = 3'd4,
      G_DBL_PRESSED   = 3'd5,
      G_DBL_PRESSING  = 3'd6,
      G_RELEASED      = 3'd7
   } gesture_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRESSED_LEVEL  = 2'd0,
      CSR_CLICK_MIN      = 2'd1,
      CSR_LONG_PRESS     = 2'd2,
      CSR_DOUBLE_WINDOW  = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic        pressed_level;
      logic [15:0] click_min_ms;
      logic [15:0] long_press_ms;
      logic [15:0] double_window_ms;
   } cfg_type;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        level;
   } sample_type;

   typedef struct packed {
      logic        triggered;
      gesture_type gesture;
   } result_type;

endpackage

`default_nettype wire

FILE: src/bgc_csr.sv
// Configuration register file of the button gesture classifier.
// Depends on bgc_pkg.
`default_nettype none

module bgc_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [bgc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [bgc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output bgc_pkg::cfg_type                     cfg
);
   import bgc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_PRESSED_LEVEL: cfg_in.pressed_level    = csr_wdata[0];
            CSR_CLICK_MIN:     cfg_in.click_min_ms     = csr_wdata;
            CSR_LONG_PRESS:    cfg_in.long_press_ms    = csr_wdata;
            CSR_DOUBLE_WINDOW: cfg_in.double_window_ms = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pressed_level    <= 1'b0;
         cfg_ff.click_min_ms     <= CLICK_MIN_RESET;
         cfg_ff.long_press_ms    <= LONG_PRESS_RESET;
         cfg_ff.double_window_ms <= DOUBLE_WINDOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: src/bgc_core.sv
// Gesture state and timestamp registers with the per-sample classification.
// Depends on bgc_pkg.
`default_nettype none

module bgc_core (
   input  wire logic           clock,
   input  wire logic           reset,
   input  bgc_pkg::cfg_type    cfg,
   input  wire logic           step,
   input  bgc_pkg::sample_type sample,
   output bgc_pkg::result_type result
);
   import bgc_pkg::*;

   gesture_type last_gesture_ff, last_gesture_in;
   logic [31:0] press_time_ff, press_time_in;
   logic [31:0] release_time_ff, release_time_in;
   logic [31:0] click_time_ff, click_time_in;

   logic [31:0] since_release;
   logic [31:0] since_press;
   logic [31:0] since_click;
   gesture_type cur;
   logic        trig;

   // All differences wrap modulo 2^32 and compare as unsigned.
   assign since_release = sample.now_ms - release_time_ff;
   assign since_press   = sample.now_ms - press_time_ff;
   assign since_click   = sample.now_ms - click_time_ff;

   always_comb begin
      cur             = last_gesture_ff;
      trig            = 1'b0;
      press_time_in   = press_time_ff;
      release_time_in = release_time_ff;
      click_time_in   = click_time_ff;

      // One-shot states fall back before the sample is looked at.
      if (last_gesture_ff == G_RELEASED) cur = G_RELEASE;
      if (last_gesture_ff == G_PRESSED)  cur = G_PRESS;

      if (sample.level == cfg.pressed_level) begin
         press_time_in = sample.now_ms;
         unique case (last_gesture_ff)
            G_RELEASE: begin
               if (since_release > DEBOUNCE_MS) cur = G_PRESS;
            end
            G_PRESS: begin
               // A long press wins over a double press.
               if (since_release > {16'd0, cfg.long_press_ms}) begin
                  cur  = G_LONG_PRESSED;
                  trig = 1'b1;
               end else if (since_click < {16'd0, cfg.double_window_ms}) begin
                  cur  = G_DBL_PRESSED;
                  trig = 1'b1;
               end
            end
            G_LONG_PRESSED: cur = G_LONG_PRESSING;
            G_DBL_PRESSED:  cur = G_DBL_PRESSING;
            default: ;
         endcase
      end else begin
         release_time_in = sample.now_ms;
         unique case (last_gesture_ff)
            G_PRESS: begin
               if (since_press > {16'd0, cfg.click_min_ms}) begin
                  cur           = G_PRESSED;
                  trig          = 1'b1;
                  press_time_in = sample.now_ms;
               end else if (since_press > DEBOUNCE_MS) begin
                  click_time_in = sample.now_ms;
               end
            end
            G_PRESSED, G_LONG_PRESSED, G_LONG_PRESSING: begin
               cur  = G_RELEASED;
               trig = 1'b1;
            end
            default: cur = G_RELEASE;
         endcase
      end

      last_gesture_in = cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_gesture_ff <= G_RELEASE;
         press_time_ff   <= '0;
         release_time_ff <= '0;
         click_time_ff   <= '0;
      end else if (step) begin
         last_gesture_ff <= last_gesture_in;
         press_time_ff   <= press_time_in;
         release_time_ff <= release_time_in;
         click_time_ff   <= click_time_in;
      end
   end

   assign result.gesture   = cur;
   assign result.triggered = trig;

endmodule

`default_nettype wire

FILE: src/button_gesture_classifier_top.sv
// Top level of the button gesture classifier: input stage, result stage.
// Depends on bgc_pkg, bgc_csr, bgc_core and button_gesture_classifier_top_assert.svh.
//
// Usage:
//   Each req transaction carries one button sample: the pin level and a
//   wrapping 32-bit millisecond timestamp. Each sample produces exactly one
//   rsp transaction with the gesture code and a trigger flag.
//   The sample is held in an input register and classified once the result
//   stage can move on; the result lands in an output register that drives
//   rsp_tvalid. Throughput is one sample per cycle while rsp_tready stays
//   high, as the gesture state and timestamp registers update per sample.
//   When the receiver stalls, the result is held and one more sample may wait
//   in the input register; req_tready then drops until the result is taken.
//   Reset clears both stages, the gesture state and timestamps and loads the
//   register defaults. Configuration is written through csr_we, csr_index and
//   csr_wdata and takes effect at the next sample; write only while idle.
`default_nettype none

module button_gesture_classifier_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Input samples.
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // Fields from bit 0: level [0], now_ms [32:1], zero fill [39:33].
   input  wire logic [bgc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // Results.
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // Fields from bit 0: gesture [2:0], triggered [3], zero fill [7:4].
   output logic [bgc_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // Configuration writes.
   input  wire logic                             csr_we,
   input  wire logic [bgc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [bgc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bgc_pkg::*;

   `include "button_gesture_classifier_top_assert.svh"

   cfg_type    cfg;
   logic       in_valid_ff, in_valid_in;
   sample_type in_data_ff, in_data_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff, out_data_in;
   result_type core_result;
   logic       advance;
   logic       step;
   logic       req_take;

   bgc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bgc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (step),
      .sample (in_data_ff),
      .result (core_result)
   );

   // The input stage moves on whenever the result stage is empty or drains.
   assign advance    = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance) begin
         in_valid_in  = 1'b0;
         out_valid_in = in_valid_ff;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_data_in  = sample_type'({req_tdata[32:1], req_tdata[0]});
      end
      if (step) out_data_in = core_result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_data_ff.triggered, out_data_ff.gesture};

   // Only the four event gestures may carry a trigger.
   `BGC_ASSERT(a_trig_gesture, clock, reset,
      !(rsp_tvalid && rsp_tdata[3]) || rsp_tdata[2:0] == G_PRESSED ||
      rsp_tdata[2:0] == G_LONG_PRESSED || rsp_tdata[2:0] == G_DBL_PRESSED ||
      rsp_tdata[2:0] == G_RELEASED,
      "trigger set on a non-event gesture")

   // A waiting sample is not lost or altered while the result stage is blocked.
   `BGC_ASSERT_NEXT(a_hold_input, clock, reset, in_valid_ff && !advance,
      in_valid_ff && $stable(in_data_ff), "input stage changed while blocked")

   // An empty input stage is always ready to take a new sample.
   `BGC_ASSERT(a_ready_empty, clock, reset, in_valid_ff || req_tready,
      "input stage empty but not ready")

endmodule

`default_nettype wire
